[rtl/sbf_pkg.sv]
// sbf_pkg: payload types, command codes and register indexes of the
// separable 3x3 binomial filter. No dependencies.
`default_nettype none

package sbf_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 8;
  localparam int FH_W       = 13;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd128;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } sbf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } sbf_out_t;

endpackage

`default_nettype wire

[rtl/sbf_line_mem.sv]
// sbf_line_mem: line buffer memory, one write port and one registered read port.
// Stand-alone, no package use.
`default_nettype none

module sbf_line_mem #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0]        wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

[rtl/sbf_out_buf.sv]
// sbf_out_buf: two-entry output buffer (head register plus skid register).
// Depends on sbf_pkg for the result type.
`default_nettype none

module sbf_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sbf_pkg::sbf_out_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sbf_pkg::sbf_out_t     out_data_o
);

  logic              head_valid_q, head_valid_d;
  logic              skid_valid_q, skid_valid_d;
  sbf_pkg::sbf_out_t head_q, head_d;
  sbf_pkg::sbf_out_t skid_q, skid_d;
  logic              pop;
  logic              head_load;

  assign pop       = head_valid_q && !out_stall_i;
  assign head_load = !head_valid_q || pop;

  always_comb begin
    head_valid_d = head_valid_q;
    head_d       = head_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (head_load) begin
      head_valid_d = skid_valid_q || push_i;
      head_d       = skid_valid_q ? skid_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full output buffer");

  a_stalled_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

[rtl/separable_binomial_3x3_filter_unit.sv]
// separable_binomial_3x3_filter_unit: top level of the 3x3 binomial filter.
// Depends on sbf_pkg, sbf_line_mem and sbf_out_buf.
// Usage: pixels enter in raster order at one per clock; the unit accepts an item in
// every cycle while the output buffer has room. The filtered pixel for raster index n
// is produced by input item n + width + 1 and leaves through a registered two-entry
// output buffer. After the last pixel of a frame, width + 1 flush items drain
// the final row; the last one carries end_of_frame. A flush outside the drain, or a pixel
// during it, is dropped. Both line buffers share one memory, written once and read once
// per item with a registered read that is prefetched for the next column; it needs no
// clearing pass after reset. Width and height saturate to [3, MAX_WIDTH] and [3, MAX_HEIGHT];
// the user must write them over the configuration port while the unit is idle (not enforced).
`default_nettype none

module separable_binomial_3x3_filter_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire sbf_pkg::sbf_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output sbf_pkg::sbf_out_t                     out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [sbf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [sbf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int PB = PIXEL_BITS;

  logic [sbf_pkg::FW_W-1:0] frame_width_q;
  logic [sbf_pkg::FH_W-1:0] frame_height_q;
  logic [CW-1:0]            width_eff;
  logic [RW-1:0]            height_eff;

  logic [CW-1:0] col_q, col_d, col_inc;
  logic [RW-1:0] row_q, row_d, row_inc;
  logic          drain_q, drain_d;
  logic [PB-1:0] win1_q, win1_d, win2_q, win2_d;

  logic              in_acc, active, last_out, first_row;
  logic [2*PB-1:0]   rd_data, wr_data;
  logic [AW-1:0]     rd_addr;
  logic [PB-1:0]     pa, pb, pix, v;
  logic [PB+1:0]     vsum, edge_sum, c1_sum, mid_sum;
  logic [PB-1:0]     res_pix;
  logic              push;
  sbf_pkg::sbf_out_t res;
  logic              buf_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sbf_pkg::FRAME_WIDTH_RST;
      frame_height_q <= sbf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sbf_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[sbf_pkg::FW_W-1:0];
        sbf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[sbf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(frame_width_q) < 3) begin
      width_eff = CW'(3);
    end else if (int'(frame_width_q) > MAX_WIDTH) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(frame_width_q);
    end
    if (int'(frame_height_q) < 3) begin
      height_eff = RW'(3);
    end else if (int'(frame_height_q) > MAX_HEIGHT) begin
      height_eff = RW'(MAX_HEIGHT);
    end else begin
      height_eff = RW'(frame_height_q);
    end
  end

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign active     = in_acc &&
                      (in_data_i.cmd == (drain_q ? sbf_pkg::CMD_FLUSH : sbf_pkg::CMD_PIXEL));
  assign last_out   = drain_q && (col_q >= width_eff);
  assign first_row  = !drain_q && (row_q == '0);

  assign col_inc = col_q + CW'(1);
  assign row_inc = row_q + RW'(1);

  // column window from the line buffers
  assign pa  = rd_data[2*PB-1:PB];
  assign pb  = rd_data[PB-1:0];
  assign pix = drain_q ? pb : PB'(in_data_i.pixel_in);

  assign vsum     = {2'b00, pa} + {1'b0, pb, 1'b0} + {2'b00, pix};
  assign v        = vsum[PB+1:2];
  assign edge_sum = {2'b00, win1_q} + {1'b0, win2_q, 1'b0} + {2'b00, win2_q};
  assign c1_sum   = {1'b0, win2_q, 1'b0} + {2'b00, win2_q} + {2'b00, v};
  assign mid_sum  = {2'b00, win1_q} + {1'b0, win2_q, 1'b0} + {2'b00, v};

  always_comb begin
    push    = 1'b0;
    res_pix = edge_sum[PB+1:2];
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    win1_d  = win1_q;
    win2_d  = win2_q;
    if (active) begin
      if (last_out) begin
        push    = 1'b1;
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        if (!first_row) begin
          win1_d = win2_q;
          win2_d = v;
          if (col_q == '0) begin
            push = drain_q || (row_q >= RW'(2));
          end else if (col_q == CW'(1)) begin
            push    = 1'b1;
            res_pix = c1_sum[PB+1:2];
          end else begin
            push    = 1'b1;
            res_pix = mid_sum[PB+1:2];
          end
        end
        if (drain_q) begin
          col_d = col_inc;
        end else if (col_inc >= width_eff) begin
          col_d = '0;
          row_d = row_inc;
          if (row_inc >= height_eff) begin
            drain_d = 1'b1;
          end
        end else begin
          col_d = col_inc;
        end
      end
    end
  end

  assign res.pixel_out    = sbf_pkg::PIX_W'(res_pix);
  assign res.end_of_frame = last_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
      win1_q  <= '0;
      win2_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      win1_q  <= win1_d;
      win2_q  <= win2_d;
    end
  end

  // prefetch the column of the next item
  assign rd_addr = active ? col_d[AW-1:0] : col_q[AW-1:0];
  assign wr_data = first_row ? {pix, pix} : {pb, pix};

  sbf_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PB)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (active && !last_out),
    .wr_addr_i (col_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sbf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_frame_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && last_out) |=> (col_q == '0) && (row_q == '0) && !drain_q)
    else $error("counters not cleared after the final transfer");

  a_eof_only_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.end_of_frame) |-> drain_q)
    else $error("end of frame outside the drain");

  a_no_result_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && first_row) |-> !push)
    else $error("result produced during the first row");

endmodule

`default_nettype wire
